// ===== design/ast_pkg.sv =====
`timescale 1ns / 1ps

package ast_pkg;

	// Result kinds.
	localparam logic [3:0] K_EOF     = 4'd0;
	localparam logic [3:0] K_ERROR   = 4'd1;
	localparam logic [3:0] K_COMMA   = 4'd2;
	localparam logic [3:0] K_LPAREN  = 4'd3;
	localparam logic [3:0] K_RPAREN  = 4'd4;
	localparam logic [3:0] K_LABEL   = 4'd5;
	localparam logic [3:0] K_IDENT   = 4'd6;
	localparam logic [3:0] K_INSTR   = 4'd7;
	localparam logic [3:0] K_DIR     = 4'd8;
	localparam logic [3:0] K_REG     = 4'd9;
	localparam logic [3:0] K_SCALAR  = 4'd10;
	localparam logic [3:0] K_STRBYTE = 4'd11;
	localparam logic [3:0] K_STREND  = 4'd12;

	// Error subcodes.
	localparam logic [31:0] E_UNEXPECTED   = 32'd0;
	localparam logic [31:0] E_BAD_DIR      = 32'd1;
	localparam logic [31:0] E_UNTERMINATED = 32'd2;

	// Longest mnemonic or directive name.
	localparam int unsigned NAME_MAX = 7;

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] value;
		logic [19:0] start;
		logic [15:0] len;
		logic [15:0] line;
	} res_t;

	// One queue entry holds every result caused by one character.
	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t e;
	} link_t;

	function automatic res_t mk_res(logic [3:0] k, logic [31:0] v, logic [31:0] s,
			logic [15:0] len, logic [15:0] line);
		res_t r;
		r.kind  = k;
		r.value = v;
		r.start = s[19:0];
		r.len   = len;
		r.line  = line;
		return r;
	endfunction

	function automatic logic is_letter(logic [7:0] c);
		return (c inside {["a":"z"], ["A":"Z"], "_"});
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return (c inside {["0":"9"]});
	endfunction

	function automatic logic is_oct(logic [7:0] c);
		return (c inside {["0":"7"]});
	endfunction

	// Returns {valid, nibble}.
	function automatic logic [4:0] hex_val(logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c inside {["0":"9"]}) r = {1'b1, 4'(c - 8'h30)};
		else if (c inside {["a":"f"]}) r = {1'b1, 4'(c - 8'h57)};
		else if (c inside {["A":"F"]}) r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	// Packs the first n stored characters right-aligned, first character highest.
	function automatic logic [55:0] word_key(logic [55:0] w, logic [15:0] n);
		logic [55:0] k;
		k = '0;
		for (int i = 0; i < 7; i++) begin
			if (16'(i) < n) k = {k[47:0], w[55 - 8 * i -: 8]};
		end
		return k;
	endfunction

	// Returns {hit, code}.
	function automatic logic [7:0] mnem_lookup(logic [55:0] k);
		logic [7:0] r;
		case (k)
			56'("abs"): r = {1'b1, 7'd0};
			56'("add"): r = {1'b1, 7'd1};
			56'("addi"): r = {1'b1, 7'd2};
			56'("addu"): r = {1'b1, 7'd3};
			56'("addiu"): r = {1'b1, 7'd4};
			56'("and"): r = {1'b1, 7'd5};
			56'("andi"): r = {1'b1, 7'd6};
			56'("div"): r = {1'b1, 7'd7};
			56'("divu"): r = {1'b1, 7'd8};
			56'("mult"): r = {1'b1, 7'd9};
			56'("multu"): r = {1'b1, 7'd10};
			56'("neg"): r = {1'b1, 7'd11};
			56'("negu"): r = {1'b1, 7'd12};
			56'("nor"): r = {1'b1, 7'd13};
			56'("not"): r = {1'b1, 7'd14};
			56'("or"): r = {1'b1, 7'd15};
			56'("rem"): r = {1'b1, 7'd16};
			56'("remu"): r = {1'b1, 7'd17};
			56'("sll"): r = {1'b1, 7'd18};
			56'("sllv"): r = {1'b1, 7'd19};
			56'("sra"): r = {1'b1, 7'd20};
			56'("srav"): r = {1'b1, 7'd21};
			56'("srl"): r = {1'b1, 7'd22};
			56'("srlv"): r = {1'b1, 7'd23};
			56'("sub"): r = {1'b1, 7'd24};
			56'("subu"): r = {1'b1, 7'd25};
			56'("xor"): r = {1'b1, 7'd26};
			56'("xori"): r = {1'b1, 7'd27};
			56'("li"): r = {1'b1, 7'd28};
			56'("slt"): r = {1'b1, 7'd29};
			56'("sltu"): r = {1'b1, 7'd30};
			56'("slti"): r = {1'b1, 7'd31};
			56'("sltiu"): r = {1'b1, 7'd32};
			56'("seq"): r = {1'b1, 7'd33};
			56'("sge"): r = {1'b1, 7'd34};
			56'("sgeu"): r = {1'b1, 7'd35};
			56'("sgt"): r = {1'b1, 7'd36};
			56'("sgtu"): r = {1'b1, 7'd37};
			56'("sle"): r = {1'b1, 7'd38};
			56'("sleu"): r = {1'b1, 7'd39};
			56'("sne"): r = {1'b1, 7'd40};
			56'("b"): r = {1'b1, 7'd41};
			56'("beq"): r = {1'b1, 7'd42};
			56'("bgez"): r = {1'b1, 7'd43};
			56'("bgtz"): r = {1'b1, 7'd44};
			56'("blez"): r = {1'b1, 7'd45};
			56'("bltz"): r = {1'b1, 7'd46};
			56'("bne"): r = {1'b1, 7'd47};
			56'("beqz"): r = {1'b1, 7'd48};
			56'("bge"): r = {1'b1, 7'd49};
			56'("bgeu"): r = {1'b1, 7'd50};
			56'("bgt"): r = {1'b1, 7'd51};
			56'("bgtu"): r = {1'b1, 7'd52};
			56'("ble"): r = {1'b1, 7'd53};
			56'("bleu"): r = {1'b1, 7'd54};
			56'("blt"): r = {1'b1, 7'd55};
			56'("bltu"): r = {1'b1, 7'd56};
			56'("bnez"): r = {1'b1, 7'd57};
			56'("j"): r = {1'b1, 7'd58};
			56'("jal"): r = {1'b1, 7'd59};
			56'("jalr"): r = {1'b1, 7'd60};
			56'("jr"): r = {1'b1, 7'd61};
			56'("la"): r = {1'b1, 7'd62};
			56'("lb"): r = {1'b1, 7'd63};
			56'("lbu"): r = {1'b1, 7'd64};
			56'("lh"): r = {1'b1, 7'd65};
			56'("lhu"): r = {1'b1, 7'd66};
			56'("lw"): r = {1'b1, 7'd67};
			56'("sb"): r = {1'b1, 7'd68};
			56'("sh"): r = {1'b1, 7'd69};
			56'("move"): r = {1'b1, 7'd70};
			56'("mfhi"): r = {1'b1, 7'd71};
			56'("mflo"): r = {1'b1, 7'd72};
			56'("mthi"): r = {1'b1, 7'd73};
			56'("mtlo"): r = {1'b1, 7'd74};
			56'("syscall"): r = {1'b1, 7'd75};
			default: r = '0;
		endcase
		return r;
	endfunction

	// Returns {hit, code}.
	function automatic logic [3:0] dir_lookup(logic [55:0] k);
		logic [3:0] r;
		case (k)
			56'("ascii"): r = {1'b1, 3'd0};
			56'("asciiz"): r = {1'b1, 3'd1};
			56'("byte"): r = {1'b1, 3'd2};
			56'("data"): r = {1'b1, 3'd3};
			56'("half"): r = {1'b1, 3'd4};
			56'("space"): r = {1'b1, 3'd5};
			56'("text"): r = {1'b1, 3'd6};
			56'("word"): r = {1'b1, 3'd7};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/assembly_source_tokenizer_top.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// input    in         push / full            ch
// result   out        empty / pop            kind value start_offset token_length
//                                            line_number last
//
// One character is taken per cycle while full is low; the lexer and its name lookups
// settle in that cycle and write all results of the character into a four-entry queue.
// Each character causes zero to two results, popped one per cycle from the queue head.
// full rises only when the queue holds four entries with results still unread.
// Reset is asynchronous and needs no clearing pass.

module assembly_source_tokenizer_top import ast_pkg::*; #(
	parameter int WORD_CHARS  = 7,
	parameter int OFFSET_BITS = 20,
	parameter int LINE_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  ch,
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  kind,
	output logic [31:0] value,
	output logic [19:0] start_offset,
	output logic [15:0] token_length,
	output logic [15:0] line_number,
	output logic        last
);

	link_t link;
	res_t  head;
	logic  take;

	assign take = push && !full;

	// Front: lexes characters into result entries.
	ast_front #(
		.WORD_CHARS  (WORD_CHARS),
		.OFFSET_BITS (OFFSET_BITS),
		.LINE_BITS   (LINE_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.ch     (ch),
		.link   (link)
	);

	// Back: queues entries and hands results out one at a time.
	ast_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.link   (link),
		.pop    (pop),
		.full   (full),
		.empty  (empty),
		.head   (head),
		.last   (last)
	);

	assign kind         = head.kind;
	assign value        = head.value;
	assign start_offset = head.start;
	assign token_length = head.len;
	assign line_number  = head.line;

`ifndef NO_ASSERTIONS
	// End of file is always the final result of its character.
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == K_EOF) |-> last) else $error("eof not last");

	// An unterminated string error is always followed by eof.
	a_unterm_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == K_ERROR && value == E_UNTERMINATED) |-> !last)
		else $error("unterminated string error marked last");

	// A string end closes its character's results.
	a_strend_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == K_STREND) |-> last) else $error("string end not last");
`endif

endmodule

// ===== design/ast_front.sv =====
`timescale 1ns / 1ps

module ast_front import ast_pkg::*; #(
	parameter int WORD_CHARS  = 7,
	parameter int OFFSET_BITS = 20,
	parameter int LINE_BITS   = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] ch,
	output link_t      link
);

	typedef enum logic [3:0] {
		M_IDLE, M_COMMENT, M_IDENT, M_DIRECTIVE, M_REGISTER,
		M_ZERO, M_DEC, M_OCT, M_HEX, M_STRING, M_STRESC
	} mode_t;

	mode_t                  mode_q, mode_n;
	logic [7:0]             word_q [WORD_CHARS];
	logic [7:0]             word_n [WORD_CHARS];
	logic [OFFSET_BITS-1:0] tstart_q, tstart_n;
	logic [OFFSET_BITS-1:0] off_q, off_n;
	logic [15:0]            run_q, run_n;
	logic [LINE_BITS-1:0]   line_q, line_n;
	logic [31:0]            acc_q, acc_n;
	res_t                   r0, r1, fin_r;
	logic [1:0]             n;

	// Saturated line number as seen by every result of this character.
	logic [31:0] line32;
	logic [15:0] line_out;
	assign line32   = 32'(line_q);
	assign line_out = (line32 > 32'd65535) ? 16'hFFFF : line32[15:0];

	// Name lookups on the stored word, for identifiers and directives.
	logic [55:0] wpack;
	logic [7:0]  mhit;
	logic [3:0]  dhit;
	logic [15:0] dlen;
	assign wpack = {word_q[0], word_q[1], word_q[2], word_q[3],
		word_q[4], word_q[5], word_q[6]};
	assign dlen  = run_q - 16'd1;
	assign mhit  = mnem_lookup(word_key(wpack, run_q));
	assign dhit  = dir_lookup(word_key(wpack, dlen));

	// Result for a pending token that the current character ends.
	always_comb begin
		case (mode_q)
			M_IDENT: begin
				if (mhit[7] && run_q <= 16'(NAME_MAX))
					fin_r = mk_res(K_INSTR, 32'(mhit[6:0]), 32'(tstart_q), run_q, line_out);
				else
					fin_r = mk_res(K_IDENT, '0, 32'(tstart_q), run_q, line_out);
			end
			M_DIRECTIVE: begin
				if (dhit[3] && dlen <= 16'(NAME_MAX))
					fin_r = mk_res(K_DIR, 32'(dhit[2:0]), 32'(tstart_q), run_q, line_out);
				else
					fin_r = mk_res(K_ERROR, E_BAD_DIR, 32'(tstart_q), run_q, line_out);
			end
			M_REGISTER: fin_r = mk_res(K_REG, '0, 32'(tstart_q), run_q, line_out);
			default: fin_r = mk_res(K_SCALAR, acc_q, 32'(tstart_q), run_q, line_out);
		endcase
	end

	// One character of lexing: next state and up to two results.
	always_comb begin
		logic [OFFSET_BITS-1:0] pos, prev;
		logic                   handled, eof, do_str;
		logic [4:0]             hv;
		logic [7:0]             esc;
		logic                   esc_ok;
		res_t                   t;

		pos     = off_q;
		prev    = off_q - OFFSET_BITS'(1);
		handled = 1'b0;
		eof     = 1'b0;
		do_str  = 1'b0;
		n       = '0;
		r0      = fin_r;
		r1      = fin_r;
		t       = fin_r;
		mode_n  = mode_q;
		word_n  = word_q;
		tstart_n = tstart_q;
		run_n   = run_q;
		line_n  = line_q;
		acc_n   = acc_q;
		hv      = hex_val(ch);
		esc_ok  = 1'b1;
		case (ch)
			"a": esc = 8'd7;
			"b": esc = 8'd8;
			"f": esc = 8'd12;
			"n": esc = 8'd10;
			"r": esc = 8'd13;
			"t": esc = 8'd9;
			"v": esc = 8'd11;
			8'h22, 8'h5C, 8'h27: esc = ch;
			default: begin
				esc    = 8'h5C;
				esc_ok = 1'b0;
			end
		endcase

		case (mode_q)
			M_COMMENT: handled = !(ch == 8'h0A || ch == 8'h00);
			M_IDENT: begin
				if (is_letter(ch) || is_digit(ch)) begin
					for (int i = 0; i < WORD_CHARS; i++)
						if (run_q == 16'(i)) word_n[i] = ch;
					if (run_n != 16'hFFFF) run_n = run_n + 16'd1;
					handled = 1'b1;
				end else if (ch == ":") begin
					if (run_n != 16'hFFFF) run_n = run_n + 16'd1;
					r0 = mk_res(K_LABEL, '0, 32'(tstart_q), run_n, line_out);
					n = 2'd1;
					mode_n = M_IDLE;
					handled = 1'b1;
				end else begin
					n = 2'd1;
				end
			end
			M_DIRECTIVE: begin
				if (is_letter(ch)) begin
					for (int i = 0; i < WORD_CHARS; i++)
						if (dlen == 16'(i)) word_n[i] = ch;
					if (run_n != 16'hFFFF) run_n = run_n + 16'd1;
					handled = 1'b1;
				end else begin
					n = 2'd1;
				end
			end
			M_REGISTER: begin
				if (is_letter(ch) || is_digit(ch)) begin
					if (run_n != 16'hFFFF) run_n = run_n + 16'd1;
					handled = 1'b1;
				end else begin
					n = 2'd1;
				end
			end
			M_ZERO: begin
				if (ch == "x" || ch == "X") begin
					if (run_n != 16'hFFFF) run_n = run_n + 16'd1;
					mode_n = M_HEX;
					handled = 1'b1;
				end else if (is_oct(ch)) begin
					if (run_n != 16'hFFFF) run_n = run_n + 16'd1;
					acc_n = 32'(ch - 8'h30);
					mode_n = M_OCT;
					handled = 1'b1;
				end else begin
					n = 2'd1;
				end
			end
			M_DEC: begin
				if (is_digit(ch)) begin
					if (run_n != 16'hFFFF) run_n = run_n + 16'd1;
					acc_n = (acc_q << 3) + (acc_q << 1) + 32'(ch - 8'h30);
					handled = 1'b1;
				end else begin
					n = 2'd1;
				end
			end
			M_OCT: begin
				if (is_oct(ch)) begin
					if (run_n != 16'hFFFF) run_n = run_n + 16'd1;
					acc_n = (acc_q << 3) + 32'(ch - 8'h30);
					handled = 1'b1;
				end else begin
					n = 2'd1;
				end
			end
			M_HEX: begin
				if (hv[4]) begin
					if (run_n != 16'hFFFF) run_n = run_n + 16'd1;
					acc_n = (acc_q << 4) + 32'(hv[3:0]);
					handled = 1'b1;
				end else begin
					n = 2'd1;
				end
			end
			M_STRING: do_str = 1'b1;
			M_STRESC: begin
				if (ch == 8'h00) begin
					r0 = mk_res(K_ERROR, E_UNTERMINATED, 32'(tstart_q), run_q, line_out);
					n = 2'd1;
					mode_n = M_IDLE;
				end else if (esc_ok) begin
					if (run_n != 16'hFFFF) run_n = run_n + 16'd1;
					acc_n = acc_n + 32'd1;
					r0 = mk_res(K_STRBYTE, 32'(esc), 32'(prev), 16'd2, line_out);
					n = 2'd1;
					mode_n = M_STRING;
					handled = 1'b1;
				end else begin
					acc_n = acc_n + 32'd1;
					r0 = mk_res(K_STRBYTE, 32'(esc), 32'(prev), 16'd1, line_out);
					n = 2'd1;
					mode_n = M_STRING;
					do_str = 1'b1;
				end
			end
			default: ;
		endcase

		// String content, possibly after a backslash that stood alone.
		if (do_str) begin
			if (ch == 8'h00) begin
				t = mk_res(K_ERROR, E_UNTERMINATED, 32'(tstart_n), run_n, line_out);
				if (n == 2'd0) r0 = t; else r1 = t;
				n = n + 2'd1;
				mode_n = M_IDLE;
			end else begin
				if (run_n != 16'hFFFF) run_n = run_n + 16'd1;
				handled = 1'b1;
				if (ch == 8'h22) begin
					t = mk_res(K_STREND, acc_n, 32'(tstart_n), run_n, line_out);
					if (n == 2'd0) r0 = t; else r1 = t;
					n = n + 2'd1;
					mode_n = M_IDLE;
				end else if (ch == 8'h5C) begin
					mode_n = M_STRESC;
				end else begin
					acc_n = acc_n + 32'd1;
					t = mk_res(K_STRBYTE, 32'(ch), 32'(pos), 16'd1, line_out);
					if (n == 2'd0) r0 = t; else r1 = t;
					n = n + 2'd1;
				end
			end
		end

		// The character starts something new, or is a token by itself.
		if (!handled) begin
			mode_n = M_IDLE;
			t = mk_res(K_ERROR, E_UNEXPECTED, 32'(pos), 16'd1, line_out);
			if (ch == 8'h00) begin
				t = mk_res(K_EOF, '0, 32'(pos), 16'd0, line_out);
				eof = 1'b1;
			end else if (ch == ",") begin
				t = mk_res(K_COMMA, '0, 32'(pos), 16'd1, line_out);
			end else if (ch == "(") begin
				t = mk_res(K_LPAREN, '0, 32'(pos), 16'd1, line_out);
			end else if (ch == ")") begin
				t = mk_res(K_RPAREN, '0, 32'(pos), 16'd1, line_out);
			end
			if (ch inside {8'h20, 8'h09, 8'h0D}) begin
			end else if (ch == 8'h0A) begin
				if (line_n != '1) line_n = line_n + LINE_BITS'(1);
			end else if (ch == "#") begin
				mode_n = M_COMMENT;
			end else if (is_letter(ch) || is_digit(ch) || ch == "." || ch == "$"
					|| ch == 8'h22) begin
				tstart_n = pos;
				run_n = 16'd1;
				acc_n = '0;
				if (is_letter(ch)) begin
					mode_n = M_IDENT;
					word_n[0] = ch;
				end else if (ch == "0") begin
					mode_n = M_ZERO;
				end else if (is_digit(ch)) begin
					mode_n = M_DEC;
					acc_n = 32'(ch - 8'h30);
				end else if (ch == ".") begin
					mode_n = M_DIRECTIVE;
				end else if (ch == "$") begin
					mode_n = M_REGISTER;
				end else begin
					mode_n = M_STRING;
				end
			end else begin
				if (n == 2'd0) r0 = t; else r1 = t;
				n = n + 2'd1;
			end
		end

		if (eof) begin
			mode_n   = M_IDLE;
			tstart_n = '0;
			off_n    = '0;
			run_n    = '0;
			line_n   = LINE_BITS'(1);
			acc_n    = '0;
		end else begin
			off_n = pos + OFFSET_BITS'(1);
		end
	end

	// Results of this character go to the queue as one transaction.
	assign link.valid = take && (n != 2'd0);
	assign link.e.two = (n == 2'd2);
	assign link.e.r0  = r0;
	assign link.e.r1  = r1;

	// Lexer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			tstart_q <= '0;
			off_q    <= '0;
			run_q    <= '0;
			line_q   <= LINE_BITS'(1);
			acc_q    <= '0;
		end else if (take) begin
			mode_q   <= mode_n;
			tstart_q <= tstart_n;
			off_q    <= off_n;
			run_q    <= run_n;
			line_q   <= line_n;
			acc_q    <= acc_n;
		end
	end

	// Stored word characters.
	always_ff @(posedge clk) begin
		if (take) word_q <= word_n;
	end

endmodule

// ===== design/ast_back.sv =====
`timescale 1ns / 1ps

module ast_back import ast_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  link_t link,
	input  logic  pop,
	output logic  full,
	output logic  empty,
	output res_t  head,
	output logic  last
);

	localparam int DEPTH = 4;
	localparam int PTR   = $clog2(DEPTH);

	entry_t         q_mem [DEPTH];
	logic [PTR-1:0] wr_q, rd_q;
	logic [PTR:0]   cnt_q;
	logic           sel_q;
	logic           pop_en, deq;
	entry_t         top_e;

	assign top_e  = q_mem[rd_q];
	assign full   = (cnt_q == (PTR + 1)'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign pop_en = pop && !empty;
	assign deq    = pop_en && (!top_e.two || sel_q);
	assign head   = sel_q ? top_e.r1 : top_e.r0;
	assign last   = sel_q || !top_e.two;

	// Queue pointers, fill count and result select within the head entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
			sel_q <= 1'b0;
		end else begin
			if (link.valid) wr_q <= wr_q + PTR'(1);
			if (deq) rd_q <= rd_q + PTR'(1);
			cnt_q <= cnt_q + (PTR + 1)'(link.valid) - (PTR + 1)'(deq);
			if (deq) sel_q <= 1'b0;
			else if (pop_en) sel_q <= 1'b1;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (link.valid) q_mem[wr_q] <= link.e;
	end

endmodule
